// ----- design/mhfp_pkg.sv -----
// Shared definitions for the message header field parser.
// Parse phase codes, result kind codes, byte codes and the result struct.
// No dependencies.
`default_nettype none

package mhfp_pkg;

   localparam logic [3:0] PH_HEADER   = 4'd0;
   localparam logic [3:0] PH_CODE     = 4'd1;
   localparam logic [3:0] PH_STR_SKIP = 4'd2;
   localparam logic [3:0] PH_STR_LEN  = 4'd3;
   localparam logic [3:0] PH_STR_TEXT = 4'd4;
   localparam logic [3:0] PH_SIG_SKIP = 4'd5;
   localparam logic [3:0] PH_SIG_CNT  = 4'd6;
   localparam logic [3:0] PH_SIG_REST = 4'd7;
   localparam logic [3:0] PH_PAR_LEN  = 4'd8;
   localparam logic [3:0] PH_PAR_TEXT = 4'd9;

   localparam logic [2:0] KIND_SERIAL    = 3'd0;
   localparam logic [2:0] KIND_PATH      = 3'd1;
   localparam logic [2:0] KIND_INTERFACE = 3'd2;
   localparam logic [2:0] KIND_DEST      = 3'd3;
   localparam logic [2:0] KIND_METHOD    = 3'd4;
   localparam logic [2:0] KIND_PARAM     = 3'd5;
   localparam logic [2:0] KIND_COUNT     = 3'd6;
   localparam logic [2:0] KIND_END       = 3'd7;

   localparam logic [7:0] CODE_PATH      = 8'd1;
   localparam logic [7:0] CODE_INTERFACE = 8'd2;
   localparam logic [7:0] CODE_METHOD    = 8'd3;
   localparam logic [7:0] CODE_DEST      = 8'd6;
   localparam logic [7:0] CODE_SIGNATURE = 8'd8;

   typedef struct packed {
      logic        have;
      logic [2:0]  kind;
      logic [31:0] value;
      logic        eos;
      logic        msg_end;
   } result_type;

endpackage

`default_nettype wire

// ----- design/mhfp_core.sv -----
// Parse state and single-pass next-state logic for one stream byte.
// Produces the result of the byte combinationally; state advances on step.
// Depends on mhfp_pkg.
`default_nettype none

module mhfp_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic [7:0]         data_byte,
   output mhfp_pkg::result_type    result
);
   import mhfp_pkg::*;

   logic [3:0]  phase_ff,   phase_in;
   logic [31:0] seg_ff,     seg_in;
   logic [31:0] pos_ff,     pos_in;
   logic [31:0] alen_ff,    alen_in;
   logic [31:0] blen_ff,    blen_in;
   logic [31:0] serial_ff,  serial_in;
   logic [31:0] slen_ff,    slen_in;
   logic [2:0]  field_ff,   field_in;
   logic [7:0]  pcount_ff,  pcount_in;
   logic [7:0]  left_ff,    left_in;

   logic [3:0]  hdr_k;
   logic [31:0] lane_hdr;
   logic [31:0] lane_len;
   logic [31:0] total;
   logic [31:0] seg_inc;
   logic [8:0]  sig_len;
   logic [2:0]  sig_pad;
   logic        finish_elem;
   logic        finish_par;
   logic        clear;
   logic        ended;

   assign hdr_k    = seg_ff[3:0];
   assign lane_hdr = {24'd0, data_byte} << {hdr_k[1:0], 3'b000};
   assign lane_len = {24'd0, data_byte} << {seg_ff[1:0], 3'b000};
   assign total    = (slen_ff + 32'd8) & ~32'd7;
   assign seg_inc  = seg_ff + 32'd1;
   assign sig_pad  = 3'd2 - data_byte[2:0];
   assign sig_len  = {1'b0, data_byte} + 9'd1 + {6'd0, sig_pad};

   always_comb begin
      phase_in    = phase_ff;
      seg_in      = seg_ff;
      pos_in      = pos_ff;
      alen_in     = alen_ff;
      blen_in     = blen_ff;
      serial_in   = serial_ff;
      slen_in     = slen_ff;
      field_in    = field_ff;
      pcount_in   = pcount_ff;
      left_in     = left_ff;
      finish_elem = 1'b0;
      finish_par  = 1'b0;
      clear       = 1'b0;
      result      = '0;

      case (phase_ff)
         PH_HEADER: begin
            case (hdr_k[3:2])
               2'b01:   blen_in   = blen_ff | lane_hdr;
               2'b10:   serial_in = serial_ff | lane_hdr;
               2'b11:   alen_in   = alen_ff | lane_hdr;
               default: ;
            endcase
            if (hdr_k == 4'd11) begin
               result.have  = 1'b1;
               result.kind  = KIND_SERIAL;
               result.value = serial_in;
            end
            if (hdr_k == 4'd15) begin
               finish_elem = 1'b1;
            end else begin
               seg_in = {28'd0, hdr_k + 4'd1};
            end
         end
         PH_CODE: begin
            seg_in = '0;
            if (data_byte inside {CODE_PATH, CODE_INTERFACE, CODE_DEST, CODE_METHOD}) begin
               case (data_byte)
                  CODE_PATH:      field_in = KIND_PATH;
                  CODE_INTERFACE: field_in = KIND_INTERFACE;
                  CODE_DEST:      field_in = KIND_DEST;
                  default:        field_in = KIND_METHOD;
               endcase
               pos_in   = pos_ff + 32'd1;
               phase_in = PH_STR_SKIP;
            end else if (data_byte == CODE_SIGNATURE) begin
               pos_in   = pos_ff + 32'd1;
               phase_in = PH_SIG_SKIP;
            end
         end
         PH_STR_SKIP, PH_SIG_SKIP: begin
            seg_in = seg_inc;
            if (seg_inc >= 32'd3) begin
               seg_in   = '0;
               phase_in = (phase_ff == PH_STR_SKIP) ? PH_STR_LEN : PH_SIG_CNT;
            end
         end
         PH_STR_LEN: begin
            slen_in = slen_ff | lane_len;
            seg_in  = seg_inc;
            if (seg_inc >= 32'd4) begin
               pos_in = pos_ff + 32'd7;
               seg_in = '0;
               if (((slen_in + 32'd8) & ~32'd7) == 32'd0) begin
                  finish_elem = 1'b1;
               end else begin
                  phase_in = PH_STR_TEXT;
               end
            end
         end
         PH_STR_TEXT: begin
            if (seg_ff < slen_ff) begin
               result.have  = 1'b1;
               result.kind  = field_ff;
               result.value = {24'd0, data_byte};
            end else if (seg_ff == slen_ff) begin
               result.have = 1'b1;
               result.kind = field_ff;
               result.eos  = 1'b1;
            end
            seg_in = seg_inc;
            if (seg_inc >= total) begin
               pos_in      = pos_ff + total;
               finish_elem = 1'b1;
            end
         end
         PH_SIG_CNT: begin
            pcount_in    = data_byte;
            pos_in       = pos_ff + 32'd4;
            result.have  = 1'b1;
            result.kind  = KIND_COUNT;
            result.value = {24'd0, data_byte};
            slen_in      = {23'd0, sig_len};
            seg_in       = '0;
            phase_in     = PH_SIG_REST;
         end
         PH_SIG_REST: begin
            seg_in = seg_inc;
            if (seg_inc >= slen_ff) begin
               pos_in      = pos_ff + slen_ff;
               finish_elem = 1'b1;
            end
         end
         PH_PAR_LEN: begin
            slen_in = slen_ff | lane_len;
            seg_in  = seg_inc;
            if (seg_inc >= 32'd4) begin
               seg_in = '0;
               if (slen_in == 32'hFFFF_FFFF) begin
                  finish_par = 1'b1;
               end else begin
                  phase_in = PH_PAR_TEXT;
               end
            end
         end
         PH_PAR_TEXT: begin
            result.have = 1'b1;
            result.kind = KIND_PARAM;
            if (seg_ff < slen_ff) begin
               result.value = {24'd0, data_byte};
            end else begin
               result.eos = 1'b1;
            end
            seg_in = seg_inc;
            if (seg_inc >= slen_ff + 32'd1) begin
               finish_par = 1'b1;
            end
         end
         default: clear = 1'b1;
      endcase

      ended = 1'b0;
      if (finish_elem) begin
         seg_in  = '0;
         slen_in = '0;
         if (pos_in < alen_in) begin
            phase_in = PH_CODE;
         end else if (blen_in != 32'd0 && pcount_in != 8'd0) begin
            left_in  = pcount_in;
            phase_in = PH_PAR_LEN;
         end else begin
            clear = 1'b1;
            ended = 1'b1;
         end
      end
      if (finish_par) begin
         seg_in  = '0;
         slen_in = '0;
         left_in = left_ff - 8'd1;
         if (left_in != 8'd0) begin
            phase_in = PH_PAR_LEN;
         end else begin
            clear = 1'b1;
            ended = 1'b1;
         end
      end
      if (clear) begin
         phase_in  = PH_HEADER;
         seg_in    = '0;
         pos_in    = '0;
         alen_in   = '0;
         blen_in   = '0;
         serial_in = '0;
         slen_in   = '0;
         field_in  = '0;
         pcount_in = '0;
         left_in   = '0;
      end

      if (ended) begin
         result.msg_end = 1'b1;
         if (!result.have) begin
            result.have  = 1'b1;
            result.kind  = KIND_END;
            result.value = '0;
            result.eos   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         seg_ff    <= '0;
         pos_ff    <= '0;
         alen_ff   <= '0;
         blen_ff   <= '0;
         serial_ff <= '0;
         slen_ff   <= '0;
         field_ff  <= '0;
         pcount_ff <= '0;
         left_ff   <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         seg_ff    <= seg_in;
         pos_ff    <= pos_in;
         alen_ff   <= alen_in;
         blen_ff   <= blen_in;
         serial_ff <= serial_in;
         slen_ff   <= slen_in;
         field_ff  <= field_in;
         pcount_ff <= pcount_in;
         left_ff   <= left_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/message_header_field_parser.sv -----
// Top level of the message header field parser: input register, parse core
// and result register with valid/stall handshakes on both sides.
// Depends on mhfp_pkg and mhfp_core.
//
// Takes one stream byte per transfer and sustains one byte per clock while
// the result side does not stall. A byte is parsed in a single pass between
// the input register and the result register, so its result (if any) is
// captured in the result register as the byte leaves the input register.
// A stalled result holds the input register, which then stalls the input
// side. Bytes that give no result (header bytes other than the last serial
// byte, padding, skipped and unknown-code bytes) produce no transfer, except
// that the last byte of a message always produces one with message_end set.
`default_nettype none

module message_header_field_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_kind,
   output logic [31:0]      rsp_value,
   output logic             rsp_end_of_string,
   output logic             rsp_message_end
);
   import mhfp_pkg::*;

   logic        in_valid_ff,  in_valid_in;
   logic [7:0]  in_byte_ff,   in_byte_in;
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff,       out_in;
   result_type  result;
   logic        advance;
   logic        take;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign in_byte_in   = take ? req_data_byte : in_byte_ff;
   assign out_valid_in = advance ? result.have : (out_valid_ff && rsp_stall);
   assign out_in       = (advance && result.have) ? result : out_ff;

   mhfp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_kind          = out_ff.kind;
   assign rsp_value         = out_ff.value;
   assign rsp_end_of_string = out_ff.eos;
   assign rsp_message_end   = out_ff.msg_end;

endmodule

`default_nettype wire
